FILE: hw/rtl/biou_pkg.sv
// ----------------------------------------------------------------------------
// biou_pkg: shared types and constants for the box overlap ratio unit
// Request and result structs, derived widths and pipeline depth.
// ----------------------------------------------------------------------------
package biou_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  localparam int END_BITS   = COORD_BITS + 1;      // left + width
  localparam int AREA_BITS  = 2 * COORD_BITS;      // width * height
  localparam int UNI_BITS   = AREA_BITS + 1;       // sum of two areas
  localparam int REM_BITS   = UNI_BITS + 1;        // doubled remainder
  localparam int RATIO_BITS = FRAC_BITS + 1;
  localparam int DIV_STAGES = FRAC_BITS + 1;       // one quotient bit per stage

  // geometry, area products, union, divider stages, output register
  localparam int LATENCY    = 3 + DIV_STAGES + 1;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] a_left;
    logic [COORD_BITS-1:0] a_top;
    logic [COORD_BITS-1:0] a_wide;
    logic [COORD_BITS-1:0] a_tall;
    logic [COORD_BITS-1:0] b_left;
    logic [COORD_BITS-1:0] b_top;
    logic [COORD_BITS-1:0] b_wide;
    logic [COORD_BITS-1:0] b_tall;
  } in_req_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] overlap_ratio;
    logic                  disjoint;
    logic                  empty_union;
  } out_res_t;

  // overlap extents and box sizes after the geometry stage
  typedef struct packed {
    logic [COORD_BITS-1:0] cols;
    logic [COORD_BITS-1:0] rows;
    logic [COORD_BITS-1:0] a_wide;
    logic [COORD_BITS-1:0] a_tall;
    logic [COORD_BITS-1:0] b_wide;
    logic [COORD_BITS-1:0] b_tall;
    logic                  disjoint;
  } geom_t;

  // dividend and divisor handed to the divider
  typedef struct packed {
    logic [AREA_BITS-1:0] inter;
    logic [UNI_BITS-1:0]  uni;
    logic                 disjoint;
    logic                 empty_union;
  } div_req_t;

endpackage

FILE: hw/rtl/biou_geom.sv
// ----------------------------------------------------------------------------
// biou_geom: separation test and overlap extents
// Compute box edges, the separation flag and the overlap width and height.
// ----------------------------------------------------------------------------
module biou_geom import biou_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  in_req_t in_req,
  output logic    geom_valid,
  output geom_t   geom
);

  logic [END_BITS-1:0] a_l, a_t, a_r, a_b;
  logic [END_BITS-1:0] b_l, b_t, b_r, b_b;
  logic [END_BITS-1:0] hi_x, lo_x, hi_y, lo_y, cols_w, rows_w;
  logic                sep;
  logic                valid_r;
  geom_t               geom_r, geom_nxt;

  always_comb begin
    a_l = {1'b0, in_req.a_left};
    a_t = {1'b0, in_req.a_top};
    b_l = {1'b0, in_req.b_left};
    b_t = {1'b0, in_req.b_top};
    a_r = a_l + {1'b0, in_req.a_wide};
    a_b = a_t + {1'b0, in_req.a_tall};
    b_r = b_l + {1'b0, in_req.b_wide};
    b_b = b_t + {1'b0, in_req.b_tall};

    sep = (a_l > b_r) || (a_t > b_b) || (a_r < b_l) || (a_b < b_t);

    hi_x = (a_r < b_r) ? a_r : b_r;
    lo_x = (a_l > b_l) ? a_l : b_l;
    hi_y = (a_b < b_b) ? a_b : b_b;
    lo_y = (a_t > b_t) ? a_t : b_t;
    // bounded by the smaller box size when not separated
    cols_w = hi_x - lo_x;
    rows_w = hi_y - lo_y;

    geom_nxt.cols     = cols_w[COORD_BITS-1:0];
    geom_nxt.rows     = rows_w[COORD_BITS-1:0];
    geom_nxt.a_wide   = in_req.a_wide;
    geom_nxt.a_tall   = in_req.a_tall;
    geom_nxt.b_wide   = in_req.b_wide;
    geom_nxt.b_tall   = in_req.b_tall;
    geom_nxt.disjoint = sep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    geom_r <= geom_nxt;
  end

  assign geom_valid = valid_r;
  assign geom       = geom_r;

endmodule

FILE: hw/rtl/biou_area.sv
// ----------------------------------------------------------------------------
// biou_area: intersection, box areas and union
// Two stages: three registered products, then union and empty test.
// ----------------------------------------------------------------------------
module biou_area import biou_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     geom_valid,
  input  geom_t    geom,
  output logic     div_valid,
  output div_req_t div_req
);

  logic [AREA_BITS-1:0] inter_r, area_a_r, area_b_r;
  logic                 disjoint_r, prod_valid_r;
  logic [UNI_BITS-1:0]  uni;
  logic                 uni_valid_r;
  div_req_t             div_req_r, div_req_nxt;

  always_comb begin
    uni = {1'b0, area_a_r} + {1'b0, area_b_r} - {1'b0, inter_r};
    div_req_nxt.inter       = inter_r;
    div_req_nxt.uni         = uni;
    div_req_nxt.disjoint    = disjoint_r;
    div_req_nxt.empty_union = !disjoint_r && (uni == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      uni_valid_r  <= 1'b0;
    end else begin
      prod_valid_r <= geom_valid;
      uni_valid_r  <= prod_valid_r;
    end
    inter_r    <= AREA_BITS'(geom.cols)   * AREA_BITS'(geom.rows);
    area_a_r   <= AREA_BITS'(geom.a_wide) * AREA_BITS'(geom.a_tall);
    area_b_r   <= AREA_BITS'(geom.b_wide) * AREA_BITS'(geom.b_tall);
    disjoint_r <= geom.disjoint;
    div_req_r  <= div_req_nxt;
  end

  assign div_valid = uni_valid_r;
  assign div_req   = div_req_r;

endmodule

FILE: hw/rtl/biou_div.sv
// ----------------------------------------------------------------------------
// biou_div: pipelined restoring divider
// One quotient bit per stage; forces zero for separated or empty pairs.
// ----------------------------------------------------------------------------
module biou_div import biou_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     div_valid,
  input  div_req_t div_req,
  output logic     res_valid,
  output out_res_t res
);

  logic [REM_BITS-1:0]   rem_r   [DIV_STAGES];
  logic [RATIO_BITS-1:0] quo_r   [DIV_STAGES];
  logic [UNI_BITS-1:0]   uni_r   [DIV_STAGES];
  logic                  disj_r  [DIV_STAGES];
  logic                  empty_r [DIV_STAGES];
  logic                  valid_r [DIV_STAGES];

  // first stage: integer bit, set when intersection is not below union
  logic [REM_BITS-1:0]   rem0, div0;
  logic                  ge0;
  logic [RATIO_BITS-1:0] quo0;

  always_comb begin
    rem0 = REM_BITS'(div_req.inter);
    div0 = REM_BITS'(div_req.uni);
    ge0  = rem0 >= div0;
    quo0 = '0;
    quo0[FRAC_BITS] = ge0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= div_valid;
    end
    rem_r[0]   <= ge0 ? rem0 - div0 : rem0;
    quo_r[0]   <= quo0;
    uni_r[0]   <= div_req.uni;
    disj_r[0]  <= div_req.disjoint;
    empty_r[0] <= div_req.empty_union;
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    logic [REM_BITS-1:0]   shifted, divisor;
    logic                  ge;
    logic [RATIO_BITS-1:0] quo_nxt;

    always_comb begin
      shifted = {rem_r[k-1][REM_BITS-2:0], 1'b0};
      divisor = REM_BITS'(uni_r[k-1]);
      ge      = shifted >= divisor;
      quo_nxt = quo_r[k-1];
      quo_nxt[FRAC_BITS-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_r[k-1];
      end
      rem_r[k]   <= ge ? shifted - divisor : shifted;
      quo_r[k]   <= quo_nxt;
      uni_r[k]   <= uni_r[k-1];
      disj_r[k]  <= disj_r[k-1];
      empty_r[k] <= empty_r[k-1];
    end
  end

  always_comb begin
    res.overlap_ratio = (disj_r[DIV_STAGES-1] || empty_r[DIV_STAGES-1]) ?
                        '0 : quo_r[DIV_STAGES-1];
    res.disjoint      = disj_r[DIV_STAGES-1];
    res.empty_union   = empty_r[DIV_STAGES-1];
  end

  assign res_valid = valid_r[DIV_STAGES-1];

endmodule

FILE: hw/rtl/box_intersection_over_union_unit.sv
// ----------------------------------------------------------------------------
// box_intersection_over_union_unit: overlap ratio of two boxes
// Pipelined intersection over union in unsigned Q1.FRAC_BITS, one pair a cycle.
// ----------------------------------------------------------------------------
// Each request carries two axis-aligned boxes (origin and size). The unit
// takes a request in every cycle (busy stays low) and returns one result per
// request, in order, through one geometry stage, two area stages, one divider
// stage per quotient bit and one output register. The depth is set by the
// restoring divider, which resolves one quotient bit per stage. The result is
// shown for one cycle under out_valid and cannot be held off; capture it then
// or lose it. Separated boxes give a zero ratio with disjoint set; a zero
// union gives a zero ratio with empty_union set. The unit holds no state
// between requests.
// ----------------------------------------------------------------------------
module box_intersection_over_union_unit import biou_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  logic     accept;
  logic     geom_valid, div_valid, res_valid;
  geom_t    geom;
  div_req_t div_req;
  out_res_t res;
  logic     out_valid_r;
  out_res_t out_res_r;

  // never stall: every stage advances each cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // edges, separation test, overlap extents
  biou_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_req     (in_req),
    .geom_valid (geom_valid),
    .geom       (geom)
  );

  // intersection and box areas, then union
  biou_area u_area (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom_valid (geom_valid),
    .geom       (geom),
    .div_valid  (div_valid),
    .div_req    (div_req)
  );

  // (inter << FRAC_BITS) / union, one bit per stage
  biou_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_valid (div_valid),
    .div_req   (div_req),
    .res_valid (res_valid),
    .res       (res)
  );

  // register the result so the strobe and payload leave a flop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
    out_res_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: hw/rtl/biou_checker.sv
// ----------------------------------------------------------------------------
// biou_checker: port-level checks for the overlap ratio unit
// Fixed latency, flag consistency and ratio range, bound to the top level.
// ----------------------------------------------------------------------------
module biou_checker import biou_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input out_res_t out_res
);

  // every accepted request yields a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after accepted request");

  // no result without an accepted request to match it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result without a request");

  // flagged results carry a zero ratio, flags exclude each other
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.disjoint || out_res.empty_union)) |->
      (out_res.overlap_ratio == '0) && !(out_res.disjoint && out_res.empty_union))
    else $error("flagged result with nonzero ratio");

  // ratio never exceeds one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.overlap_ratio <= RATIO_ONE))
    else $error("ratio above one");

endmodule

bind box_intersection_over_union_unit biou_checker u_biou_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
